[hw/rtl/trmfp_pkg.sv]
// shared types and codes for the token ring mac frame parser
package trmfp_pkg;

    localparam int QueueDepthDefault = 2;

    localparam logic [1:0] KindHeader = 2'd0;
    localparam logic [1:0] KindSub    = 2'd1;
    localparam logic [1:0] KindStop   = 2'd2;

    localparam logic [1:0] StatusOk         = 2'd0;
    localparam logic [1:0] StatusUnknownId  = 2'd1;
    localparam logic [1:0] StatusBadBeacon  = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] frame_length;
        logic [3:0]  source_class;
        logic [3:0]  dest_class;
        logic [7:0]  major_vector;
        logic        major_known;
        logic [7:0]  subvector_id;
        logic [7:0]  subvector_length;
        logic [47:0] decoded_value;
        logic [1:0]  subvector_status;
        logic        truncated;
        logic        last_of_frame;
    } t_out;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] total_length;
        logic [7:0]  class_byte;
        logic [7:0]  major_code;
        logic [7:0]  sub_id;
        logic [7:0]  sub_length;
        logic [47:0] value_bytes;
        logic [10:0] error_total;
        logic        truncated;
        logic        last;
    } t_cmd;

endpackage

[hw/rtl/trmfp_front.sv]
// front end: takes frame bytes, tracks header and subvector position, issues requests
module trmfp_front
    import trmfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_in,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_total, n_total;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_major, n_major;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_id, n_id;
    logic [47:0] r_val, n_val;
    logic [10:0] r_err, n_err;
    logic        r_stopped, n_stopped;

    logic        accept;
    logic        start;
    logic [15:0] c_count;
    logic [15:0] c_total;
    logic [7:0]  c_pos;
    logic        c_stopped;
    logic [7:0]  b;
    logic [7:0]  k;
    logic        last_byte;
    logic        done;
    logic        emit;
    logic [1:0]  kind;
    logic        trunc;
    logic        last;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign start   = i_in.frame_start;
    assign b       = i_in.byte_value;

    always_comb begin
        c_count   = start ? 16'd0 : r_count;
        c_total   = start ? 16'd0 : r_total;
        c_pos     = start ? 8'd0 : r_pos;
        c_stopped = start ? 1'b0 : r_stopped;
        k         = c_pos - 8'd2;
        last_byte = ({1'b0, c_count} + 17'd1) == {1'b0, c_total};
        n_count   = r_count;
        n_total   = r_total;
        n_class   = r_class;
        n_major   = r_major;
        n_len     = r_len;
        n_pos     = r_pos;
        n_id      = r_id;
        n_val     = r_val;
        n_err     = r_err;
        n_stopped = r_stopped;
        emit      = 1'b0;
        kind      = KindHeader;
        trunc     = 1'b0;
        last      = 1'b0;
        done      = 1'b0;
        if (accept) begin
            if (start) begin
                n_count = 16'd0;
                n_total = 16'd0;
                n_class = 8'd0;
                n_major = 8'd0;
                n_len   = 8'd0;
                n_pos   = 8'd0;
                n_id    = 8'd0;
                n_val   = 48'd0;
                n_err   = 11'd0;
            end
            n_stopped = c_stopped;
            if (!c_stopped) begin
                n_count = c_count + 16'd1;
                if (c_count == 16'd0) begin
                    n_total = {b, 8'd0};
                end else if (c_count == 16'd1) begin
                    n_total = {c_total[15:8], b};
                end else if (c_count == 16'd2) begin
                    n_class = b;
                end else if (c_count == 16'd3) begin
                    n_major = b;
                    emit    = 1'b1;
                    kind    = KindHeader;
                    if (c_total <= 16'd4) begin
                        n_stopped = 1'b1;
                        last      = 1'b1;
                    end
                end else if (c_pos == 8'd0 && b == 8'd0) begin
                    n_len     = 8'd0;
                    n_id      = 8'd0;
                    n_val     = 48'd0;
                    n_err     = 11'd0;
                    n_stopped = 1'b1;
                    emit      = 1'b1;
                    kind      = KindStop;
                    last      = 1'b1;
                end else begin
                    if (c_pos == 8'd0) begin
                        n_len = b;
                        n_id  = 8'd0;
                        n_val = 48'd0;
                        n_err = 11'd0;
                    end else if (c_pos == 8'd1) begin
                        n_id = b;
                    end else begin
                        if (k < 8'd6) begin
                            case (k[2:0])
                                3'd0:    n_val[47:40] = b;
                                3'd1:    n_val[39:32] = b;
                                3'd2:    n_val[31:24] = b;
                                3'd3:    n_val[23:16] = b;
                                3'd4:    n_val[15:8]  = b;
                                default: n_val[7:0]   = b;
                            endcase
                        end
                        if (k < 8'd5) begin
                            n_err = r_err + {3'd0, b};
                        end
                    end
                    done = ({1'b0, c_pos} + 9'd1) >= {1'b0, n_len};
                    if (done || last_byte) begin
                        emit  = 1'b1;
                        kind  = KindSub;
                        trunc = !done;
                        last  = last_byte;
                        n_pos = 8'd0;
                        if (last_byte) begin
                            n_stopped = 1'b1;
                        end
                    end else begin
                        n_pos = c_pos + 8'd1;
                    end
                end
            end
        end
    end

    assign o_push = accept && emit;

    always_comb begin
        o_cmd.kind         = kind;
        o_cmd.total_length = n_total;
        o_cmd.class_byte   = n_class;
        o_cmd.major_code   = n_major;
        o_cmd.sub_id       = n_id;
        o_cmd.sub_length   = n_len;
        o_cmd.value_bytes  = n_val;
        o_cmd.error_total  = n_err;
        o_cmd.truncated    = trunc;
        o_cmd.last         = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 16'd0;
            r_total   <= 16'd0;
            r_class   <= 8'd0;
            r_major   <= 8'd0;
            r_len     <= 8'd0;
            r_pos     <= 8'd0;
            r_id      <= 8'd0;
            r_val     <= 48'd0;
            r_err     <= 11'd0;
            r_stopped <= 1'b1;
        end else begin
            r_count   <= n_count;
            r_total   <= n_total;
            r_class   <= n_class;
            r_major   <= n_major;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_id      <= n_id;
            r_val     <= n_val;
            r_err     <= n_err;
            r_stopped <= n_stopped;
        end
    end

endmodule

[hw/rtl/trmfp_queue.sv]
// request queue between the front end and the decode stage
module trmfp_queue
    import trmfp_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    t_cmd            r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = r_count == CntW'(Depth);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("push not counted");
`endif

endmodule

[hw/rtl/trmfp_back.sv]
// back end: decodes queued requests into records and holds the output register
module trmfp_back
    import trmfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_out
);

    localparam logic [7:0] SvBeaconType      = 8'h01;
    localparam logic [7:0] SvUpstreamNbr     = 8'h02;
    localparam logic [7:0] SvLocalRing       = 8'h03;
    localparam logic [7:0] SvAssignDrop      = 8'h04;
    localparam logic [7:0] SvErrTimer        = 8'h05;
    localparam logic [7:0] SvAuthClass       = 8'h06;
    localparam logic [7:0] SvAuthPriority    = 8'h07;
    localparam logic [7:0] SvCorrelator      = 8'h09;
    localparam logic [7:0] SvLastNbrAddr     = 8'h0A;
    localparam logic [7:0] SvDropNumber      = 8'h0B;
    localparam logic [7:0] SvResponseCode    = 8'h20;
    localparam logic [7:0] SvAddrCount       = 8'h21;
    localparam logic [7:0] SvProductId       = 8'h22;
    localparam logic [7:0] SvStationVersion  = 8'h23;
    localparam logic [7:0] SvWrapData        = 8'h26;
    localparam logic [7:0] SvFrameForward    = 8'h27;
    localparam logic [7:0] SvStationStatus   = 8'h29;
    localparam logic [7:0] SvXmitStatus      = 8'h2A;
    localparam logic [7:0] SvGroupAddr       = 8'h2B;
    localparam logic [7:0] SvFuncAddr        = 8'h2C;
    localparam logic [7:0] SvIsoErrors       = 8'h2D;
    localparam logic [7:0] SvNonIsoErrors    = 8'h2E;
    localparam logic [7:0] SvErrorCode       = 8'h30;

    t_out        r_out, n_out;
    logic        r_valid;
    logic [15:0] w16;
    logic [31:0] w32;
    logic [19:0] times_ten;
    logic [47:0] value;
    logic [1:0]  status;
    logic        known;
    logic        is_sub;

    assign w16       = i_head.value_bytes[47:32];
    assign w32       = i_head.value_bytes[47:16];
    assign times_ten = {1'b0, w16, 3'b000} + {3'b000, w16, 1'b0};
    assign is_sub    = i_head.kind == KindSub;
    assign o_pop     = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        value  = 48'd0;
        status = StatusOk;
        unique case (i_head.sub_id) inside
            SvBeaconType: begin
                value = {32'd0, w16};
                if (w16 >= 16'd4) begin
                    status = StatusBadBeacon;
                end
            end
            SvLocalRing, SvAuthClass, SvAuthPriority, SvCorrelator,
            SvAddrCount, SvXmitStatus, SvErrorCode: begin
                value = {32'd0, w16};
            end
            SvAssignDrop, SvDropNumber, SvGroupAddr, SvFuncAddr: begin
                value = {16'd0, w32};
            end
            SvUpstreamNbr, SvLastNbrAddr, SvResponseCode: begin
                value = i_head.value_bytes;
            end
            SvErrTimer: begin
                value = {28'd0, times_ten};
            end
            SvWrapData, SvFrameForward: begin
                value = (i_head.sub_length >= 8'd2)
                      ? {40'd0, i_head.sub_length - 8'd2} : 48'd0;
            end
            SvIsoErrors, SvNonIsoErrors: begin
                value = {37'd0, i_head.error_total};
            end
            SvProductId, SvStationVersion, SvStationStatus: begin
                value = 48'd0;
            end
            default: begin
                status = StatusUnknownId;
            end
        endcase
    end

    always_comb begin
        unique case (i_head.major_code) inside
            8'h00, [8'h02:8'h07], 8'h09, [8'h0B:8'h10], 8'h20, [8'h22:8'h2A]: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    always_comb begin
        n_out.record_kind      = i_head.kind;
        n_out.frame_length     = i_head.total_length;
        n_out.source_class     = i_head.class_byte[3:0];
        n_out.dest_class       = i_head.class_byte[7:4];
        n_out.major_vector     = i_head.major_code;
        n_out.major_known      = known;
        n_out.subvector_id     = is_sub ? i_head.sub_id : 8'd0;
        n_out.subvector_length = is_sub ? i_head.sub_length : 8'd0;
        n_out.decoded_value    = is_sub ? value : 48'd0;
        n_out.subvector_status = is_sub ? status : StatusOk;
        n_out.truncated        = is_sub && i_head.truncated;
        n_out.last_of_frame    = i_head.last;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

[hw/rtl/token_ring_mac_frame_parser.sv]
// top level of the token ring mac frame parser
// Takes one MAC frame byte per cycle and returns header, subvector and stop
// records. The front end handles each byte in the cycle it is accepted;
// bytes that finish a record place a request in a small queue, and the decode
// stage turns the head of that queue into a record in the output register.
// Sustained rate is one byte per clock; a record goes through the queue and
// then the output register. The input stalls only when the queue
// (QueueDepth entries, at least 2) is full because the output is not taken.
module token_ring_mac_frame_parser
    import trmfp_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic full;
    logic push;
    t_cmd cmd;
    logic pop;
    logic q_valid;
    t_cmd head;

    trmfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    trmfp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    trmfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_out     (o_out)
    );

endmodule

[verif/tb.sv]
// testbench for the token ring mac frame parser: predicts every record per byte and checks it
module tb;
    import trmfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClockHalfPeriod = 10;
    localparam int CycleLimit = 200000;
    localparam int ReportLimit = 40;
    localparam int DrainCycles = 6;

    localparam logic [7:0] IdBeaconType        = 8'h01;
    localparam logic [7:0] IdUpstreamAddr      = 8'h02;
    localparam logic [7:0] IdLocalRing         = 8'h03;
    localparam logic [7:0] IdPhysDropAssign    = 8'h04;
    localparam logic [7:0] IdErrorTimer        = 8'h05;
    localparam logic [7:0] IdFunctionClasses   = 8'h06;
    localparam logic [7:0] IdAccessPriority    = 8'h07;
    localparam logic [7:0] IdCorrelator        = 8'h09;
    localparam logic [7:0] IdLastNeighbor      = 8'h0A;
    localparam logic [7:0] IdPhysDrop          = 8'h0B;
    localparam logic [7:0] IdResponseCode      = 8'h20;
    localparam logic [7:0] IdReserved          = 8'h21;
    localparam logic [7:0] IdProductInstance   = 8'h22;
    localparam logic [7:0] IdStationVersion    = 8'h23;
    localparam logic [7:0] IdWrapData          = 8'h26;
    localparam logic [7:0] IdFrameForward      = 8'h27;
    localparam logic [7:0] IdStationStatus     = 8'h29;
    localparam logic [7:0] IdTransmitStatus    = 8'h2A;
    localparam logic [7:0] IdGroupAddr         = 8'h2B;
    localparam logic [7:0] IdFunctionalAddr    = 8'h2C;
    localparam logic [7:0] IdIsolatingErrors   = 8'h2D;
    localparam logic [7:0] IdNonIsolatingErrors = 8'h2E;
    localparam logic [7:0] IdErrorCode         = 8'h30;

    localparam logic [7:0] MajorResponse       = 8'h00;
    localparam logic [7:0] MajorBeacon         = 8'h02;
    localparam logic [7:0] MajorDupAddrTest    = 8'h07;
    localparam logic [7:0] MajorTransmitFwd    = 8'h09;
    localparam logic [7:0] MajorRemoveStation  = 8'h0B;
    localparam logic [7:0] MajorReqAttachments = 8'h10;
    localparam logic [7:0] MajorReqInit        = 8'h20;
    localparam logic [7:0] MajorReportAddrs    = 8'h22;
    localparam logic [7:0] MajorReportTxFwd    = 8'h2A;

    localparam logic [15:0] BeaconTypeLimit = 16'd4;
    localparam logic [47:0] ErrorTimerScale = 48'd10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    token_ring_mac_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // parser state mirror
    logic [15:0] byte_index = '0;
    logic [15:0] frame_len = '0;
    logic [7:0]  class_q = '0;
    logic [7:0]  major_q = '0;
    logic [7:0]  sv_len = '0;
    logic [7:0]  sv_pos = '0;
    logic [7:0]  sv_id = '0;
    logic [47:0] sv_value = '0;
    logic [10:0] err_sum = '0;
    logic        stopped = 1'b1;

    t_out pending_records [$];
    t_out want_record;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   parsed_bytes = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_off_cycles = 0;

    always #ClockHalfPeriod i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic t_out record_base(logic [1:0] kind);
        t_out rec;
        rec = '0;
        rec.record_kind  = kind;
        rec.frame_length = frame_len;
        rec.source_class = class_q[3:0];
        rec.dest_class   = class_q[7:4];
        rec.major_vector = major_q;
        rec.major_known  = (major_q == MajorResponse)
            || (major_q >= MajorBeacon && major_q <= MajorDupAddrTest)
            || (major_q == MajorTransmitFwd)
            || (major_q >= MajorRemoveStation && major_q <= MajorReqAttachments)
            || (major_q == MajorReqInit)
            || (major_q >= MajorReportAddrs && major_q <= MajorReportTxFwd);
        return rec;
    endfunction

    task automatic decode_frame_byte(input t_in item);
        t_out rec;
        int   idx;
        int   k;
        logic last_byte;
        logic done;
        logic [7:0] b;
        b = item.byte_value;
        if (item.frame_start) begin
            byte_index = '0;
            frame_len = '0;
            class_q = '0;
            major_q = '0;
            sv_len = '0;
            sv_pos = '0;
            sv_id = '0;
            sv_value = '0;
            err_sum = '0;
            stopped = 1'b0;
        end
        if (stopped) return;
        parsed_bytes++;
        idx = int'(byte_index);
        byte_index = byte_index + 16'd1;
        case (idx)
            0: begin
                frame_len = {b, 8'h00};
                return;
            end
            1: begin
                frame_len[7:0] = b;
                return;
            end
            2: begin
                class_q = b;
                return;
            end
            3: begin
                major_q = b;
                if (frame_len <= 16'd4) stopped = 1'b1;
                rec = record_base(KindHeader);
                rec.last_of_frame = stopped;
                pending_records.push_back(rec);
                return;
            end
            default: ;
        endcase

        last_byte = (idx + 1 == int'(frame_len));
        if (sv_pos == 8'd0) begin
            sv_len = b;
            sv_id = '0;
            sv_value = '0;
            err_sum = '0;
            if (b == 8'd0) begin
                stopped = 1'b1;
                rec = record_base(KindStop);
                rec.last_of_frame = 1'b1;
                pending_records.push_back(rec);
                return;
            end
        end else if (sv_pos == 8'd1) begin
            sv_id = b;
        end else begin
            k = int'(sv_pos) - 2;
            if (k < 6) sv_value = sv_value | ({40'd0, b} << (40 - 8 * k));
            if (k < 5) err_sum = err_sum + {3'b000, b};
        end

        done = (int'(sv_pos) + 1 >= int'(sv_len));
        if (done || last_byte) begin
            rec = record_base(KindSub);
            rec.subvector_id = sv_id;
            rec.subvector_length = sv_len;
            rec.subvector_status = StatusOk;
            case (sv_id)
                IdBeaconType: begin
                    rec.decoded_value = {32'd0, sv_value[47:32]};
                    if (sv_value[47:32] >= BeaconTypeLimit) rec.subvector_status = StatusBadBeacon;
                end
                IdLocalRing, IdFunctionClasses, IdAccessPriority, IdCorrelator, IdReserved,
                IdTransmitStatus, IdErrorCode:
                    rec.decoded_value = {32'd0, sv_value[47:32]};
                IdPhysDropAssign, IdPhysDrop, IdGroupAddr, IdFunctionalAddr:
                    rec.decoded_value = {16'd0, sv_value[47:16]};
                IdUpstreamAddr, IdLastNeighbor, IdResponseCode:
                    rec.decoded_value = sv_value;
                IdErrorTimer:
                    rec.decoded_value = {32'd0, sv_value[47:32]} * ErrorTimerScale;
                IdWrapData, IdFrameForward:
                    rec.decoded_value = (sv_len >= 8'd2) ? {40'd0, sv_len - 8'd2} : '0;
                IdIsolatingErrors, IdNonIsolatingErrors:
                    rec.decoded_value = {37'd0, err_sum};
                IdProductInstance, IdStationVersion, IdStationStatus:
                    rec.decoded_value = '0;
                default: begin
                    rec.decoded_value = '0;
                    rec.subvector_status = StatusUnknownId;
                end
            endcase
            rec.truncated = !done;
            rec.last_of_frame = last_byte;
            pending_records.push_back(rec);
            if (last_byte) stopped = 1'b1;
            sv_pos = '0;
        end else begin
            sv_pos = sv_pos + 8'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_records.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit)
                    $display("%0t: record expected none actual %h", $time, o_out);
            end else begin
                want_record = pending_records.pop_front();
                check_field("record_kind", 48'(want_record.record_kind),
                            48'(o_out.record_kind));
                check_field("frame_length", 48'(want_record.frame_length),
                            48'(o_out.frame_length));
                check_field("source_class", 48'(want_record.source_class),
                            48'(o_out.source_class));
                check_field("dest_class", 48'(want_record.dest_class),
                            48'(o_out.dest_class));
                check_field("major_vector", 48'(want_record.major_vector),
                            48'(o_out.major_vector));
                check_field("major_known", 48'(want_record.major_known),
                            48'(o_out.major_known));
                check_field("subvector_id", 48'(want_record.subvector_id),
                            48'(o_out.subvector_id));
                check_field("subvector_length", 48'(want_record.subvector_length),
                            48'(o_out.subvector_length));
                check_field("decoded_value", want_record.decoded_value, o_out.decoded_value);
                check_field("subvector_status", 48'(want_record.subvector_status),
                            48'(o_out.subvector_status));
                check_field("truncated", 48'(want_record.truncated),
                            48'(o_out.truncated));
                check_field("last_of_frame", 48'(want_record.last_of_frame),
                            48'(o_out.last_of_frame));
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic start);
        t_in item;
        item.byte_value = value;
        item.frame_start = start;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (!o_in_ready);
        decode_frame_byte(item);
    endtask

    task automatic wait_all_records();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic [7:0] MajorClaimless();
        return MajorBeacon + 8'd1;
    endfunction

    task automatic test_truncated_subvector();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h0C, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(MajorClaimless(), 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(IdErrorTimer, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(IdUpstreamAddr, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
    endtask

    task automatic test_zero_length_stop();
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(MajorResponse, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
    endtask

    task automatic test_restart_into_short_frame();
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(MajorReportTxFwd, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(IdIsolatingErrors, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h04, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_output_backpressure();
        int n_sub;
        n_sub = $urandom_range(30, 40);
        hold_off_cycles = 60;
        send_byte(8'h00, 1'b1);
        send_byte(8'(n_sub + 4), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat (n_sub) send_byte(8'h01, 1'b0);
    endtask

    task automatic send_random_frame();
        logic [7:0]  body [$];
        logic [7:0]  id;
        logic [7:0]  v;
        logic [7:0]  b;
        logic [15:0] frame_total;
        int n_sub, n_val, sub_len, shape, n_send;
        n_sub = $urandom_range(1, 5);
        repeat (n_sub) begin
            n_val = 2;
            case ($urandom_range(0, 22))
                0:  id = IdBeaconType;
                1:  id = IdLocalRing;
                2:  id = IdFunctionClasses;
                3:  id = IdAccessPriority;
                4:  id = IdCorrelator;
                5:  id = IdReserved;
                6:  id = IdTransmitStatus;
                7:  id = IdErrorCode;
                8:  id = IdErrorTimer;
                9:  begin id = IdPhysDropAssign; n_val = 4; end
                10: begin id = IdPhysDrop; n_val = 4; end
                11: begin id = IdGroupAddr; n_val = 4; end
                12: begin id = IdFunctionalAddr; n_val = 4; end
                13: begin id = IdUpstreamAddr; n_val = 6; end
                14: begin id = IdLastNeighbor; n_val = 6; end
                15: begin id = IdResponseCode; n_val = 6; end
                16: begin id = IdIsolatingErrors; n_val = 5; end
                17: begin id = IdNonIsolatingErrors; n_val = 5; end
                18: begin id = IdWrapData; n_val = $urandom_range(0, 3); end
                19: begin id = IdFrameForward; n_val = $urandom_range(0, 3); end
                20: begin id = IdProductInstance; n_val = $urandom_range(0, 3); end
                21: begin id = IdStationVersion; n_val = $urandom_range(0, 3); end
                default: begin id = IdStationStatus; n_val = $urandom_range(0, 3); end
            endcase
            if ($urandom_range(0, 6) == 0) id = 8'($urandom_range(0, 255));
            sub_len = n_val + 2;
            if ($urandom_range(0, 4) == 0) sub_len = $urandom_range(1, 12);
            if ($urandom_range(0, 29) == 0) sub_len = 0;
            body.push_back(sub_len[7:0]);
            if (sub_len >= 2) body.push_back(id);
            for (int k = 2; k < sub_len; k++) begin
                case ($urandom_range(0, 3))
                    0: v = 8'h00;
                    1: v = 8'hFF;
                    2: v = 8'($urandom_range(0, 5));
                    default: v = 8'($urandom_range(0, 255));
                endcase
                body.push_back(v);
            end
        end

        n_send = 4 + body.size();
        frame_total = n_send[15:0];
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            // header only, length too short for subvectors
            frame_total = 16'($urandom_range(0, 4));
            n_send = 4;
        end else if (shape == 1) begin
            n_send = 4 + $urandom_range(1, body.size());
            frame_total = n_send[15:0];
        end else if (shape == 2) begin
            frame_total = 16'(frame_total + $urandom_range(1, 300));
        end else if (shape == 3) begin
            n_send = $urandom_range(1, n_send - 1);
        end

        for (int i = 0; i < n_send; i++) begin
            case (i)
                0: b = frame_total[15:8];
                1: b = frame_total[7:0];
                2: b = 8'($urandom_range(0, 255));
                3: b = $urandom_range(0, 1) ? 8'($urandom_range(0, 47))
                                            : 8'($urandom_range(0, 255));
                default: b = body[i - 4];
            endcase
            send_byte(b, (i == 0) || ($urandom_range(0, 49) == 0));
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_random_frames(input int target);
        int goal;
        goal = parsed_bytes + target;
        while (parsed_bytes < goal) send_random_frame();
    endtask

    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 68;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_truncated_subvector();
        test_zero_length_stop();
        test_restart_into_short_frame();
        wait_all_records();

        test_random_frames(160);
        test_output_backpressure();
        wait_all_records();

        send_idle_pct = 68;
        recv_idle_pct = 11;
        test_random_frames(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(160);
        wait_all_records();

        if (mismatch_count == 0 && pending_records.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
